// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the droplet block's RTL.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent from the next cycle on
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dsfs_pkg.sv =====
// Package for the droplet size and fall speed block: widths, constants, regime codes.
// No dependencies.
package dsfs_pkg;

   localparam int CUBE_FRAC_BITS = 8;

   localparam int IN_W    = 48;
   localparam int RAD_W   = 24;
   localparam int MASS_W  = 51;
   localparam int SPEED_W = 24;

   localparam int CR_STEPS = 27;
   localparam int CR_N_W   = 3 * CR_STEPS;
   localparam int CR_REM_W = 64;
   localparam int CR_Y_W   = CR_STEPS;
   localparam int CR_Y2_W  = 2 * CR_STEPS;
   localparam int CR_SHIFT = 30 - CUBE_FRAC_BITS;

   localparam int SQ_STEPS = 22;
   localparam int SQ_N_W   = 2 * SQ_STEPS;
   localparam int SQ_REM_W = SQ_STEPS + 3;
   localparam int SQ_SHIFT = 20;

   localparam int MASS_K_W    = 35;
   localparam int MASS_HALF_W = IN_W / 2;
   localparam int MASS_PP_W   = MASS_HALF_W + MASS_K_W;
   localparam int MASS_SUM_W  = 96;
   localparam int MASS_SHIFT  = 24 + CUBE_FRAC_BITS;
   localparam logic [MASS_K_W-1:0] MASS_K = 35'd17990716939;

   localparam logic [127:0] THRESH_0 =
      ((128'd13443 * 128'd13443 * 128'd13443) << CUBE_FRAC_BITS) / 128'd8000000;
   localparam logic [127:0] THRESH_1 =
      ((128'd151164 * 128'd151164 * 128'd151164) << CUBE_FRAC_BITS) / 128'd8000000;
   localparam logic [127:0] THRESH_2 =
      ((128'd347784 * 128'd347784 * 128'd347784) << CUBE_FRAC_BITS) / 128'd8000000;

   localparam int K0_W = 23;
   localparam int K1_W = 29;
   localparam int K2_W = 34;
   localparam logic [K0_W-1:0] K_REG0 = 23'd7798727;
   localparam logic [K1_W-1:0] K_REG1 = 29'd524203065;
   localparam logic [K2_W-1:0] K_REG2 = 34'd14411502060;
   localparam logic [SPEED_W-1:0] SPEED_REG3 = 24'd9170000;

   localparam int SHIFT_REG0 = 36;
   localparam int SHIFT_REG1 = 26;
   localparam int SHIFT_REG2 = 31;

   typedef enum logic [1:0] {
      REGIME_POW23,
      REGIME_POW13,
      REGIME_POW16,
      REGIME_CONST
   } regime_type;

endpackage

// ===== hdl/droplet_size_and_fall_speed.sv =====
// rsp_valid is registered; a request passes p0, p1, the root stages, f1, f2 and out.
// Throughput: one transaction per cycle; busy is always low since the receiver cannot stall.
// The 27-step cube root and the 22-step square root are one stage per result bit.
// Reset (synchronous, active high) clears all valid bits; payload registers keep their value.
// Uses dsfs_pkg and assert_macros.svh.
module droplet_size_and_fall_speed
   import dsfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IN_W-1:0]      req_cubed_radius,
   output logic                 rsp_valid,
   output logic [RAD_W-1:0]     rsp_radius_um,
   output logic [MASS_W-1:0]    rsp_mass_pg,
   output logic [SPEED_W-1:0]   rsp_fall_speed,
   output logic [1:0]           rsp_regime
);

`include "assert_macros.svh"

   logic                  p0_valid_ff;
   logic [IN_W-1:0]       p0_c_ff;

   logic                  p1_valid_ff;
   logic [IN_W-1:0]       p1_c_ff;
   logic [MASS_PP_W-1:0]  p1_pp_lo_ff;
   logic [MASS_PP_W-1:0]  p1_pp_hi_ff;
   regime_type            p1_regime_ff;
   regime_type            p1_regime_in;

   logic                  cr_valid_ff  [0:CR_STEPS];
   logic [CR_N_W-1:0]     cr_n_ff      [0:CR_STEPS];
   logic [CR_REM_W-1:0]   cr_rem_ff    [0:CR_STEPS];
   logic [CR_Y_W-1:0]     cr_y_ff      [0:CR_STEPS];
   logic [CR_Y2_W-1:0]    cr_y2_ff     [0:CR_STEPS];
   logic [MASS_W-1:0]     cr_mass_ff   [0:CR_STEPS];
   regime_type            cr_regime_ff [0:CR_STEPS];

   logic [CR_N_W-1:0]     cr_n_in      [1:CR_STEPS];
   logic [CR_REM_W-1:0]   cr_rem_in    [1:CR_STEPS];
   logic [CR_Y_W-1:0]     cr_y_in      [1:CR_STEPS];
   logic [CR_Y2_W-1:0]    cr_y2_in     [1:CR_STEPS];
   logic [CR_REM_W-1:0]   cr_rsh       [0:CR_STEPS-1];
   logic [CR_REM_W-1:0]   cr_trial     [0:CR_STEPS-1];

   logic [MASS_SUM_W-1:0] mass_sum;

   logic                  sq_valid_ff  [0:SQ_STEPS];
   logic [SQ_N_W-1:0]     sq_n_ff      [0:SQ_STEPS];
   logic [SQ_REM_W-1:0]   sq_rem_ff    [0:SQ_STEPS];
   logic [SQ_STEPS-1:0]   sq_y_ff      [0:SQ_STEPS];
   logic [RAD_W-1:0]      sq_r_ff      [0:SQ_STEPS];
   logic [MASS_W-1:0]     sq_mass_ff   [0:SQ_STEPS];
   regime_type            sq_regime_ff [0:SQ_STEPS];

   logic [SQ_N_W-1:0]     sq_n_in      [1:SQ_STEPS];
   logic [SQ_REM_W-1:0]   sq_rem_in    [1:SQ_STEPS];
   logic [SQ_STEPS-1:0]   sq_y_in      [1:SQ_STEPS];
   logic [SQ_REM_W-1:0]   sq_rsh       [0:SQ_STEPS-1];
   logic [SQ_REM_W-1:0]   sq_trial     [0:SQ_STEPS-1];

   logic                        f1_valid_ff;
   logic [2*RAD_W-1:0]          f1_rr_ff;
   logic [K1_W+RAD_W-1:0]       f1_p1_ff;
   logic [K2_W+SQ_STEPS-1:0]    f1_p2_ff;
   logic [RAD_W-1:0]            f1_r_ff;
   logic [MASS_W-1:0]           f1_mass_ff;
   regime_type                  f1_regime_ff;

   logic                        f2_valid_ff;
   logic [RAD_W+K0_W-1:0]       f2_s0a_ff;
   logic [RAD_W+K0_W-1:0]       f2_s0b_ff;
   logic [SPEED_W-1:0]          f2_sp1_ff;
   logic [SPEED_W-1:0]          f2_sp2_ff;
   logic [RAD_W-1:0]            f2_r_ff;
   logic [MASS_W-1:0]           f2_mass_ff;
   regime_type                  f2_regime_ff;

   logic [63:0]                 s0_sum;
   logic [SPEED_W-1:0]          speed_in;

   logic                        out_valid_ff;
   logic [RAD_W-1:0]            out_r_ff;
   logic [MASS_W-1:0]           out_mass_ff;
   logic [SPEED_W-1:0]          out_speed_ff;
   regime_type                  out_regime_ff;

   assign busy = 1'b0;

   // regime from exact threshold compares on the input
   always_comb begin
      priority if ({80'd0, p0_c_ff} <= THRESH_0) begin
         p1_regime_in = REGIME_POW23;
      end else if ({80'd0, p0_c_ff} <= THRESH_1) begin
         p1_regime_in = REGIME_POW13;
      end else if ({80'd0, p0_c_ff} <= THRESH_2) begin
         p1_regime_in = REGIME_POW16;
      end else begin
         p1_regime_in = REGIME_CONST;
      end
   end

   assign mass_sum = MASS_SUM_W'(p1_pp_lo_ff) + (MASS_SUM_W'(p1_pp_hi_ff) << MASS_HALF_W);

   // cube root: one result bit per stage, remainder and y^2 kept incrementally
   always_comb begin
      for (int k = 0; k < CR_STEPS; k++) begin
         cr_rsh[k]   = {cr_rem_ff[k][CR_REM_W-4:0], cr_n_ff[k][CR_N_W-1 -: 3]};
         cr_trial[k] = (CR_REM_W'(cr_y2_ff[k]) << 3) + (CR_REM_W'(cr_y2_ff[k]) << 2)
                     + (CR_REM_W'(cr_y_ff[k]) << 2) + (CR_REM_W'(cr_y_ff[k]) << 1)
                     + CR_REM_W'(1);
         cr_n_in[k+1] = cr_n_ff[k] << 3;
         if (cr_rsh[k] >= cr_trial[k]) begin
            cr_rem_in[k+1] = cr_rsh[k] - cr_trial[k];
            cr_y_in[k+1]   = {cr_y_ff[k][CR_Y_W-2:0], 1'b1};
            cr_y2_in[k+1]  = (cr_y2_ff[k] << 2) + (CR_Y2_W'(cr_y_ff[k]) << 2)
                           + CR_Y2_W'(1);
         end else begin
            cr_rem_in[k+1] = cr_rsh[k];
            cr_y_in[k+1]   = {cr_y_ff[k][CR_Y_W-2:0], 1'b0};
            cr_y2_in[k+1]  = cr_y2_ff[k] << 2;
         end
      end
   end

   // square root of the radius: one result bit per stage
   always_comb begin
      for (int j = 0; j < SQ_STEPS; j++) begin
         sq_rsh[j]   = {sq_rem_ff[j][SQ_REM_W-3:0], sq_n_ff[j][SQ_N_W-1 -: 2]};
         sq_trial[j] = {1'b0, sq_y_ff[j], 2'b01};
         sq_n_in[j+1] = sq_n_ff[j] << 2;
         if (sq_rsh[j] >= sq_trial[j]) begin
            sq_rem_in[j+1] = sq_rsh[j] - sq_trial[j];
            sq_y_in[j+1]   = {sq_y_ff[j][SQ_STEPS-2:0], 1'b1};
         end else begin
            sq_rem_in[j+1] = sq_rsh[j];
            sq_y_in[j+1]   = {sq_y_ff[j][SQ_STEPS-2:0], 1'b0};
         end
      end
   end

   assign s0_sum = 64'(f2_s0a_ff) + (64'(f2_s0b_ff) << RAD_W);

   always_comb begin
      unique case (f2_regime_ff)
         REGIME_POW23: speed_in = s0_sum[SHIFT_REG0 +: SPEED_W];
         REGIME_POW13: speed_in = f2_sp1_ff;
         REGIME_POW16: speed_in = f2_sp2_ff;
         REGIME_CONST: speed_in = SPEED_REG3;
         default:      speed_in = SPEED_REG3;
      endcase
   end

   always_ff @(posedge clock) begin
      p0_c_ff <= req_cubed_radius;

      p1_c_ff      <= p0_c_ff;
      p1_pp_lo_ff  <= MASS_PP_W'(p0_c_ff[MASS_HALF_W-1:0]) * MASS_PP_W'(MASS_K);
      p1_pp_hi_ff  <= MASS_PP_W'(p0_c_ff[IN_W-1:MASS_HALF_W]) * MASS_PP_W'(MASS_K);
      p1_regime_ff <= p1_regime_in;

      cr_n_ff[0]      <= CR_N_W'(p1_c_ff) << CR_SHIFT;
      cr_rem_ff[0]    <= '0;
      cr_y_ff[0]      <= '0;
      cr_y2_ff[0]     <= '0;
      cr_mass_ff[0]   <= mass_sum[MASS_SHIFT +: MASS_W];
      cr_regime_ff[0] <= p1_regime_ff;
      for (int k = 1; k <= CR_STEPS; k++) begin
         cr_n_ff[k]      <= cr_n_in[k];
         cr_rem_ff[k]    <= cr_rem_in[k];
         cr_y_ff[k]      <= cr_y_in[k];
         cr_y2_ff[k]     <= cr_y2_in[k];
         cr_mass_ff[k]   <= cr_mass_ff[k-1];
         cr_regime_ff[k] <= cr_regime_ff[k-1];
      end

      sq_r_ff[0]      <= cr_y_ff[CR_STEPS][RAD_W-1:0];
      sq_n_ff[0]      <= SQ_N_W'(cr_y_ff[CR_STEPS][RAD_W-1:0]) << SQ_SHIFT;
      sq_rem_ff[0]    <= '0;
      sq_y_ff[0]      <= '0;
      sq_mass_ff[0]   <= cr_mass_ff[CR_STEPS];
      sq_regime_ff[0] <= cr_regime_ff[CR_STEPS];
      for (int j = 1; j <= SQ_STEPS; j++) begin
         sq_r_ff[j]      <= sq_r_ff[j-1];
         sq_n_ff[j]      <= sq_n_in[j];
         sq_rem_ff[j]    <= sq_rem_in[j];
         sq_y_ff[j]      <= sq_y_in[j];
         sq_mass_ff[j]   <= sq_mass_ff[j-1];
         sq_regime_ff[j] <= sq_regime_ff[j-1];
      end

      f1_rr_ff     <= (2*RAD_W)'(sq_r_ff[SQ_STEPS]) * (2*RAD_W)'(sq_r_ff[SQ_STEPS]);
      f1_p1_ff     <= (K1_W+RAD_W)'(K_REG1) * (K1_W+RAD_W)'(sq_r_ff[SQ_STEPS]);
      f1_p2_ff     <= (K2_W+SQ_STEPS)'(K_REG2) * (K2_W+SQ_STEPS)'(sq_y_ff[SQ_STEPS]);
      f1_r_ff      <= sq_r_ff[SQ_STEPS];
      f1_mass_ff   <= sq_mass_ff[SQ_STEPS];
      f1_regime_ff <= sq_regime_ff[SQ_STEPS];

      f2_s0a_ff    <= (RAD_W+K0_W)'(f1_rr_ff[RAD_W-1:0]) * (RAD_W+K0_W)'(K_REG0);
      f2_s0b_ff    <= (RAD_W+K0_W)'(f1_rr_ff[2*RAD_W-1:RAD_W]) * (RAD_W+K0_W)'(K_REG0);
      f2_sp1_ff    <= f1_p1_ff[SHIFT_REG1 +: SPEED_W];
      f2_sp2_ff    <= f1_p2_ff[SHIFT_REG2 +: SPEED_W];
      f2_r_ff      <= f1_r_ff;
      f2_mass_ff   <= f1_mass_ff;
      f2_regime_ff <= f1_regime_ff;

      out_r_ff      <= f2_r_ff;
      out_mass_ff   <= f2_mass_ff;
      out_speed_ff  <= speed_in;
      out_regime_ff <= f2_regime_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         for (int k = 0; k <= CR_STEPS; k++) begin
            cr_valid_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= SQ_STEPS; j++) begin
            sq_valid_ff[j] <= 1'b0;
         end
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff    <= start && !busy;
         p1_valid_ff    <= p0_valid_ff;
         cr_valid_ff[0] <= p1_valid_ff;
         for (int k = 1; k <= CR_STEPS; k++) begin
            cr_valid_ff[k] <= cr_valid_ff[k-1];
         end
         sq_valid_ff[0] <= cr_valid_ff[CR_STEPS];
         for (int j = 1; j <= SQ_STEPS; j++) begin
            sq_valid_ff[j] <= sq_valid_ff[j-1];
         end
         f1_valid_ff  <= sq_valid_ff[SQ_STEPS];
         f2_valid_ff  <= f1_valid_ff;
         out_valid_ff <= f2_valid_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_radius_um  = out_r_ff;
   assign rsp_mass_pg    = out_mass_ff;
   assign rsp_fall_speed = out_speed_ff;
   assign rsp_regime     = out_regime_ff;

   `ASSERT_IMPL(a_const_speed, rsp_valid && rsp_regime == REGIME_CONST, rsp_fall_speed == SPEED_REG3, "constant regime speed wrong")
   `ASSERT_IMPL(a_zero_drop, rsp_valid && rsp_radius_um == '0, rsp_mass_pg == '0 && rsp_regime == REGIME_POW23, "zero radius with nonzero mass or regime")
   `ASSERT_NEXT(a_enter_root, start && !busy, ##2 cr_valid_ff[0], "transaction lost before cube root")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for droplet_size_and_fall_speed: drives cubed radii, predicts
// radius, mass, fall speed and regime, and compares each response in order.
// Depends on dsfs_pkg and the droplet_size_and_fall_speed RTL.
`timescale 1ns / 100ps

module tb
   import dsfs_pkg::*;
;

   typedef struct {
      logic [RAD_W-1:0]   radius;
      logic [MASS_W-1:0]  mass;
      logic [SPEED_W-1:0] speed;
      regime_type         regime;
   } droplet_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [IN_W-1:0]     req_cubed_radius = '0;
   logic                rsp_valid;
   logic [RAD_W-1:0]    rsp_radius_um;
   logic [MASS_W-1:0]   rsp_mass_pg;
   logic [SPEED_W-1:0]  rsp_fall_speed;
   logic [1:0]          rsp_regime;

   logic [IN_W-1:0] radius_cubes[$];
   droplet_type     droplets_due[$];
   int              mismatches = 0;
   int              gap_left = 0;
   bit              stim_done = 0;

   droplet_size_and_fall_speed dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cubed_radius(req_cubed_radius), .rsp_valid(rsp_valid),
      .rsp_radius_um(rsp_radius_um), .rsp_mass_pg(rsp_mass_pg),
      .rsp_fall_speed(rsp_fall_speed), .rsp_regime(rsp_regime)
   );

   always #1 clock = ~clock;

   function automatic droplet_type predict_droplet(logic [IN_W-1:0] c);
      droplet_type    d;
      logic [127:0]   n, cand, lhs, rhs;
      logic [63:0]    y, s, sq_n, sc;
      logic [127:0]   prod;
      logic [63:0]    cent[3];
      cent[0] = 64'd13443; cent[1] = 64'd151164; cent[2] = 64'd347784;
      n = 128'(c) << (30 - CUBE_FRAC_BITS);
      y = 0;
      for (int b = 26; b >= 0; b--) begin
         cand = 128'(y | (64'd1 << b));
         if (cand * cand * cand <= n) y = cand[63:0];
      end
      d.radius = y[RAD_W-1:0];
      prod = 128'(c) * 128'd17990716939;
      d.mass = MASS_W'(prod >> (24 + CUBE_FRAC_BITS));
      lhs = 128'(c) * 128'd8000000;
      d.regime = REGIME_CONST;
      for (int i = 2; i >= 0; i--) begin
         rhs = (128'(cent[i]) * cent[i] * cent[i]) << CUBE_FRAC_BITS;
         if (lhs <= rhs) d.regime = regime_type'(i);
      end
      y = 64'(d.radius);
      case (d.regime)
         REGIME_POW23: prod = (128'd7798727 * y * y) >> 36;
         REGIME_POW13: prod = (128'd524203065 * y) >> 26;
         REGIME_POW16: begin
            sq_n = y << 20;
            s = 0;
            for (int b = 31; b >= 0; b--) begin
               sc = s | (64'd1 << b);
               if (sc * sc <= sq_n) s = sc;
            end
            prod = (128'd14411502060 * s) >> 31;
         end
         default: prod = 128'd9170000;
      endcase
      d.speed = prod[SPEED_W-1:0];
      return d;
   endfunction

   function automatic logic [IN_W-1:0] random_cube();
      logic [IN_W-1:0] v;
      int k;
      v = IN_W'({$urandom, $urandom});
      k = $urandom_range(0, 9);
      if (k < 6) v = v >> $urandom_range(0, IN_W - 1);
      else if (k == 6) v = THRESH_0[IN_W-1:0] + IN_W'($urandom_range(0, 4)) - 2;
      else if (k == 7) v = THRESH_1[IN_W-1:0] + IN_W'($urandom_range(0, 4)) - 2;
      else if (k == 8) v = THRESH_2[IN_W-1:0] + IN_W'($urandom_range(0, 4)) - 2;
      return v;
   endfunction

   initial begin
      logic [IN_W-1:0] t[3];
      t[0] = THRESH_0[IN_W-1:0]; t[1] = THRESH_1[IN_W-1:0]; t[2] = THRESH_2[IN_W-1:0];
      radius_cubes.push_back('0);
      radius_cubes.push_back(IN_W'(1));
      radius_cubes.push_back('1);
      radius_cubes.push_back({1'b1, {(IN_W-1){1'b0}}});
      radius_cubes.push_back(48'h5555_5555_5555);
      radius_cubes.push_back(48'hAAAA_AAAA_AAAA);
      for (int i = 0; i < 3; i++) begin
         radius_cubes.push_back(t[i] - 1);
         radius_cubes.push_back(t[i]);
         radius_cubes.push_back(t[i] + 1);
         radius_cubes.push_back(t[i] + 2);
      end
      radius_cubes.push_back(IN_W'(1) << CUBE_FRAC_BITS);
      radius_cubes.push_back(IN_W'(1000) << CUBE_FRAC_BITS);
      for (int i = 0; i < 1900; i++) radius_cubes.push_back(random_cube());
   end

   // driver
   always @(negedge clock) begin
      if (reset || radius_cubes.size() == 0) begin
         start <= 1'b0;
         if (!reset && radius_cubes.size() == 0 && !(start && !busy)) stim_done <= 1;
      end else if (start && busy) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_cubed_radius <= radius_cubes.pop_front();
      end
   end

   // monitor
   always @(posedge clock) begin
      droplet_type e;
      if (!reset) begin
         if (start && !busy) droplets_due.push_back(predict_droplet(req_cubed_radius));
         if (rsp_valid) begin
            if (droplets_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction at %0t", $realtime);
            end else begin
               e = droplets_due.pop_front();
               if (rsp_radius_um !== e.radius || rsp_mass_pg !== e.mass ||
                   rsp_fall_speed !== e.speed || rsp_regime !== e.regime) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp r=%0d m=%0d v=%0d g=%0d got r=%0d m=%0d v=%0d g=%0d",
                              e.radius, e.mass, e.speed, e.regime, rsp_radius_um,
                              rsp_mass_pg, rsp_fall_speed, rsp_regime);
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (stim_done);
      wait (droplets_due.size() == 0);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && droplets_due.size() == 0) $display("PASS droplet_size_and_fall_speed");
      else $display("FAIL droplet_size_and_fall_speed");
      $finish;
   end

   initial begin
      #200000;
      $display("FAIL droplet_size_and_fall_speed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dsfs_pkg.sv
hdl/droplet_size_and_fall_speed.sv
tb/sv/tb.sv
